/* rtl/tso_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and the sine table builder for the table sine oscillator
// no dependencies

package tso_pkg;

    localparam int TABLE_DEPTH_DEF = 512;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int PERIOD_W = 24;
    localparam int SAMPLE_W = 15;
    localparam int SET_W    = 7;
    localparam int FRAC_W   = 16;
    localparam int MAX_SET  = 64;

    localparam longint unsigned PiQ30     = 64'd3373259426;
    localparam longint unsigned TwoPiQ30  = 64'd6746518852;
    localparam longint unsigned HalfPiQ30 = 64'd1686629713;
    localparam longint unsigned SampleMax = 64'd16383;

    // taylor series denominators (2k)(2k+1) for k = 1..10
    localparam longint unsigned TaylorDiv [10] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_RUN
    } state_t;

    // shift-subtract long division, used only while building the table
    function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], n[b]};
            if (r >= d)
            begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // sin(x) for x in [0, pi/2], q30 in and out
    function automatic longint unsigned sin_q30(longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint unsigned acc;
        x2   = (x * x) >> 30;
        term = x;
        acc  = x;
        for (int k = 1; k <= 10; k++)
        begin
            term = (term * x2) >> 30;
            term = udiv(term, TaylorDiv[k-1]);
            if (k % 2 == 1)
                acc = (acc >= term) ? acc - term : 64'd0;
            else
                acc = acc + term;
        end
        return acc;
    endfunction

    // one table entry: sin(2*pi*i/depth) * 2^sbits / 5, rounded half up, saturated
    function automatic sample_t rom_entry(longint unsigned depth, int sbits,
                                          longint unsigned i);
        longint unsigned x;
        longint unsigned s;
        longint unsigned mag;
        logic            neg;
        sample_t         m;
        x   = udiv(i * TwoPiQ30 + (depth >> 1), depth);
        neg = 1'b0;
        if (x >= PiQ30)
        begin
            neg = 1'b1;
            x   = x - PiQ30;
        end
        if (x > HalfPiQ30)
            x = (x <= PiQ30) ? PiQ30 - x : 64'd0;
        s   = sin_q30(x);
        mag = udiv((s << sbits) + (64'd5 << 29), 64'd5 << 30);
        if (mag > SampleMax)
            mag = SampleMax;
        m = sample_t'(mag[SAMPLE_W-1:0]);
        return neg ? -m : m;
    endfunction

endpackage

/* rtl/tso_period_if.sv */
`timescale 1ns / 1ps
// input channel of the table sine oscillator: one period word per handshake
// depends on tso_pkg

interface tso_period_if;
    logic                          valid;
    logic                          ready;
    logic [tso_pkg::PERIOD_W-1:0]  period_q8;

    modport source (output valid, output period_q8, input ready);
    modport sink   (input valid, input period_q8, output ready);
endinterface

/* rtl/tso_sample_if.sv */
`timescale 1ns / 1ps
// output channel of the table sine oscillator: one sample word per handshake
// depends on tso_pkg

interface tso_sample_if;
    logic              valid;
    logic              ready;
    tso_pkg::sample_t  sample;
    logic              last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

/* rtl/table_sine_oscillator_top.sv */
`timescale 1ns / 1ps
// table sine oscillator: per period word, a phase step division (none for a zero period) then set_count sine samples
// the divider yields DIV_W = log2(TABLE_DEPTH) + 25 quotient bits, one per cycle,
// 34 at the default depth
// a new word is taken only in idle, after the last sample of the set has been read;
// one sample per cycle while the sink keeps up
// reset: phase and step cleared, set_size = 64; depends on tso_pkg and both interfaces

module table_sine_oscillator_top #(
    parameter int TABLE_DEPTH = tso_pkg::TABLE_DEPTH_DEF,
    parameter int SAMPLE_BITS = tso_pkg::SAMPLE_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [tso_pkg::SET_W-1:0]  cfg_wr_data,
    tso_period_if.sink                 period,
    tso_sample_if.source               samples
);

    // widths that follow from the table depth (a power of two)
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int PH_W  = IDX_W + tso_pkg::FRAC_W;          // phase / step, q.16
    localparam int DIV_W = IDX_W + tso_pkg::PERIOD_W + 1;    // quotient bits of depth<<24
    localparam int CNT_W = $clog2(DIV_W);
    localparam int PER_W = tso_pkg::PERIOD_W;
    localparam int SET_W = tso_pkg::SET_W;

    localparam logic [PH_W:0]      Wrap    = (PH_W+1)'(TABLE_DEPTH) << tso_pkg::FRAC_W;
    localparam logic [SET_W-1:0]   MaxSet  = SET_W'(tso_pkg::MAX_SET);
    localparam logic [CNT_W-1:0]   CntTop  = CNT_W'(DIV_W - 1);

    typedef tso_pkg::sample_t rom_t [TABLE_DEPTH];

    function automatic rom_t build_rom();
        rom_t r;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            r[i] = tso_pkg::rom_entry(longint'(TABLE_DEPTH), SAMPLE_BITS, longint'(i));
        end
        return r;
    endfunction

    // sine table, read through a registered port
    localparam rom_t SineRom = build_rom();

    // control state
    tso_pkg::state_t     state_reg, state_next;
    logic [SET_W-1:0]    set_size_reg;
    logic [SET_W-1:0]    remaining_reg, remaining_next;
    logic [PH_W-1:0]     phase_reg, phase_next;
    logic [PH_W-1:0]     step_reg, step_next;
    logic                out_valid_reg, out_valid_next;

    // divider
    logic [CNT_W-1:0]    div_cnt_reg, div_cnt_next;
    logic [PER_W-1:0]    divisor_reg;
    logic [PER_W-1:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]    quo_reg, quo_next;

    // output word, filled by the table read
    tso_pkg::sample_t    sample_reg;
    logic                last_reg;

    // handshake / datapath controls
    logic                accept;
    logic                rd_en;
    logic                div_done;
    logic [SET_W-1:0]    set_count;
    logic [PER_W:0]      trial;
    logic                trial_ge;
    logic                dvd_bit;
    logic [PH_W:0]       phase_sum;

    assign accept    = period.valid && period.ready;
    assign div_done  = (state_reg == tso_pkg::S_DIV) && (div_cnt_reg == '0);
    // samples per set, anything above the maximum set size counts as the maximum
    assign set_count = (set_size_reg > MaxSet) ? MaxSet : set_size_reg;

    // restoring division of depth<<24 by the period: the dividend is a single one bit
    assign dvd_bit   = (div_cnt_reg == CntTop);
    assign trial     = {rem_reg, dvd_bit};
    assign trial_ge  = trial >= {1'b0, divisor_reg};
    assign phase_sum = {1'b0, phase_reg} + {1'b0, step_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tso_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (period.period_q8 != '0)
                        state_next = tso_pkg::S_DIV;
                    else if (set_count != '0)
                        state_next = tso_pkg::S_RUN;
                end
            end
            tso_pkg::S_DIV:
            begin
                if (div_done)
                    state_next = (remaining_reg != '0) ? tso_pkg::S_RUN : tso_pkg::S_IDLE;
            end
            tso_pkg::S_RUN:
            begin
                if (rd_en && remaining_reg == SET_W'(1))
                    state_next = tso_pkg::S_IDLE;
            end
            default:
            begin
                state_next = tso_pkg::S_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        period.ready = 1'b0;
        rd_en        = 1'b0;
        case (state_reg)
            tso_pkg::S_IDLE:
            begin
                // takes the next word even while the last sample still waits
                period.ready = 1'b1;
            end
            tso_pkg::S_DIV:
            begin
                period.ready = 1'b0;
            end
            tso_pkg::S_RUN:
            begin
                // read only when the output word is free or leaving now
                rd_en = !out_valid_reg || samples.ready;
            end
            default:
            begin
                period.ready = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        remaining_next = remaining_reg;
        phase_next     = phase_reg;
        step_next      = step_reg;
        div_cnt_next   = div_cnt_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        out_valid_next = out_valid_reg;

        if (accept)
        begin
            remaining_next = set_count;
            div_cnt_next   = CntTop;
            rem_next       = '0;
            quo_next       = '0;
        end

        if (state_reg == tso_pkg::S_DIV)
        begin
            rem_next     = trial_ge ? PER_W'(trial - {1'b0, divisor_reg}) : trial[PER_W-1:0];
            quo_next     = {quo_reg[DIV_W-2:0], trial_ge};
            div_cnt_next = div_cnt_reg - CNT_W'(1);
            if (div_done)
            begin
                // step saturates just below the table size
                step_next = (|quo_next[DIV_W-1:PH_W]) ? {PH_W{1'b1}} : quo_next[PH_W-1:0];
            end
        end

        if (rd_en)
        begin
            remaining_next = remaining_reg - SET_W'(1);
            // phase wraps once it reaches the table size
            phase_next     = (phase_sum >= Wrap) ? PH_W'(phase_sum - Wrap)
                                                 : phase_sum[PH_W-1:0];
            out_valid_next = 1'b1;
        end
        else if (samples.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tso_pkg::S_IDLE;
            set_size_reg  <= MaxSet;
            remaining_reg <= '0;
            phase_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            remaining_reg <= remaining_next;
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            div_cnt_reg   <= div_cnt_next;
            if (cfg_wr_en)
                set_size_reg <= cfg_wr_data;
        end
    end

    // divider payload
    always_ff @(posedge clk)
    begin
        if (accept)
            divisor_reg <= period.period_q8;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    // synchronous table read straight into the output word
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            sample_reg <= SineRom[phase_reg[PH_W-1:tso_pkg::FRAC_W]];
            last_reg   <= (remaining_reg == SET_W'(1));
        end
    end

    assign samples.valid  = out_valid_reg;
    assign samples.sample = sample_reg;
    assign samples.last   = last_reg;

`ifndef SYNTHESIS
    // no reads left over once the sequencer is back to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tso_pkg::S_IDLE) |-> (remaining_reg == '0))
        else $error("samples pending while idle");

    // a nonzero period always goes through the divider
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && period.period_q8 != '0) |=> (state_reg == tso_pkg::S_DIV))
        else $error("nonzero period skipped the divider");

    // any nonzero period yields a nonzero step
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |=> (step_reg != '0))
        else $error("divider produced a zero step");

    // the final read of a set is flagged last and presented
    assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && remaining_reg == SET_W'(1)) |=> (out_valid_reg && last_reg))
        else $error("final sample not flagged last");
`endif

endmodule
